// ----- rtl/upd_pkg.sv -----
// Package: shared types, character codes and digit helpers for the URL percent decoder.
`default_nettype none
package upd_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam int unsigned DIGIT_RADIX = 16;
  localparam logic [5:0] LETTER_BASE = 6'd10;

  // Escape tracking; the unused code falls back to plain text.
  typedef enum logic [1:0] {
    PH_TEXT  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  // Up to three results produced by one request.
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      count;
    logic            data_ok;
    logic            msg_last;
  } group_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // Only called on alphanumerics; maps 0-9 -> 0..9, letters -> 10..35.
  function automatic logic [5:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    d = c - 8'h30;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      d = d + {2'b00, LETTER_BASE};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61;
      d = d + {2'b00, LETTER_BASE};
    end
    return d[5:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/upd_in_if.sv -----
// Interface: encoded byte request channel.
`default_nettype none
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/upd_out_if.sv -----
// Interface: decoded byte result channel.
`default_nettype none
interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       run_last;
  logic       message_end;

  modport source (output valid, output out_byte, output out_valid, output run_last,
                  output message_end, input ready);
  modport sink   (input valid, input out_byte, input out_valid, input run_last,
                  input message_end, output ready);
endinterface
`default_nettype wire

// ----- rtl/url_percent_decoder.sv -----
// Top level: URL percent decoder with input register, decode stage and result buffer.
`default_nettype none
// URL percent decoder. Takes one encoded byte per request on ingress and returns the
// decoded bytes on egress: '+' becomes a space, '%' plus two alphanumerics becomes one
// byte (digits 0-9, letters A-Z/a-z worth 10..35, value taken mod 256), and a broken
// escape passes its '%' and followers through as ordinary text. A message that ends
// inside an escape drops the pending '%' and its follower. The final result of each
// request carries run_last; the final result of a message also carries message_end, and
// a message-ending request with no data yields one result with out_valid low. Rate: one
// request per cycle while egress is ready, as long as each yields at most one result; a
// request yielding two or three results holds the result buffer until all are taken,
// since that buffer drives egress one result per cycle while egress is ready. A result
// passes through the input register, then the result buffer. Requests that produce
// nothing (the '%' or first digit of an escape) still advance through the decode stage.
module url_percent_decoder (
  input  wire logic clk,
  input  wire logic rst,
  upd_in_if.sink    ingress,
  upd_out_if.source egress
);

  // input register
  logic       ireg_valid;
  logic [7:0] ireg_byte;
  logic       ireg_last;

  logic            dec_fire;
  logic            buf_can_load;
  logic            grp_load;
  upd_pkg::group_t grp;

  // The decode stage advances whenever the result buffer can take a new group;
  // requests that produce no result advance too and simply load nothing.
  assign dec_fire      = ireg_valid && buf_can_load;
  assign ingress.ready = !ireg_valid || dec_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (ingress.ready) begin
      ireg_valid <= ingress.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ingress.valid && ingress.ready) begin
      ireg_byte <= ingress.in_byte;
      ireg_last <= ingress.in_last;
    end
  end

  upd_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .fire     (dec_fire),
    .cur_byte (ireg_byte),
    .cur_last (ireg_last),
    .grp      (grp),
    .grp_load (grp_load)
  );

  upd_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .grp      (grp),
    .grp_load (grp_load),
    .can_load (buf_can_load),
    .egress   (egress)
  );

`ifndef SYNTH
  // A message-ending request always produces at least one result.
  a_last_loads: assert property (@(posedge clk) disable iff (rst)
    dec_fire && ireg_last |-> grp_load)
    else $error("message end produced no result");

  // The empty marker is a lone final result of a message.
  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    egress.valid && !egress.out_valid |-> egress.run_last && egress.message_end)
    else $error("empty marker not flagged as message end");

  // A loaded group is only accepted when the buffer is free or finishing.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    grp_load |-> buf_can_load && ireg_valid)
    else $error("result group loaded over pending results");

  // After a message-ending result is taken, a new group or an idle buffer follows.
  a_end_then_next: assert property (@(posedge clk) disable iff (rst)
    egress.valid && egress.ready && egress.message_end && !grp_load |=> !egress.valid)
    else $error("results left over after message end");
`endif

endmodule
`default_nettype wire

// ----- rtl/upd_decode.sv -----
// Module: escape state and single-pass decode of one byte into a result group.
`default_nettype none
module upd_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  wire logic [7:0]    cur_byte,
  input  wire logic          cur_last,
  output upd_pkg::group_t    grp,
  output logic               grp_load
);

  upd_pkg::phase_t phase, phase_next;
  logic [7:0]      held;
  logic            held_we;

  logic            b_alnum;
  logic            p_emit;   // plain byte yields data
  logic [7:0]      p_byte;
  logic [7:0]      esc_val;
  logic [5:0]      dv_hi, dv_lo;

  always_comb begin
    b_alnum = upd_pkg::is_alnum(cur_byte);
    p_emit  = (cur_byte != upd_pkg::CH_PCT);
    p_byte  = (cur_byte == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : cur_byte;
    dv_hi   = upd_pkg::digit_value(held);
    dv_lo   = upd_pkg::digit_value(cur_byte);
    esc_val = {dv_hi[3:0], 4'b0000} + {2'b00, dv_lo};   // mod 256
  end

  always_comb begin
    grp        = '0;
    phase_next = upd_pkg::PH_TEXT;
    held_we    = 1'b0;
    grp.data_ok  = 1'b1;
    grp.msg_last = cur_last;

    case (phase)
      upd_pkg::PH_PCT: begin
        if (cur_last) begin
          // truncated escape: drop
        end else if (b_alnum) begin
          held_we    = 1'b1;
          phase_next = upd_pkg::PH_DIGIT;
        end else begin
          grp.data[0] = upd_pkg::CH_PCT;
          grp.data[1] = p_byte;
          grp.count   = p_emit ? 2'd2 : 2'd1;
          if (!p_emit) phase_next = upd_pkg::PH_PCT;
        end
      end
      upd_pkg::PH_DIGIT: begin
        if (b_alnum) begin
          grp.data[0] = esc_val;
          grp.count   = 2'd1;
        end else begin
          grp.data[0] = upd_pkg::CH_PCT;
          grp.data[1] = held;
          grp.data[2] = p_byte;
          grp.count   = p_emit ? 2'd3 : 2'd2;
          if (!p_emit) phase_next = upd_pkg::PH_PCT;
        end
      end
      default: begin
        grp.data[0] = p_byte;
        grp.count   = p_emit ? 2'd1 : 2'd0;
        if (!p_emit) phase_next = upd_pkg::PH_PCT;
      end
    endcase

    if (cur_last) begin
      phase_next = upd_pkg::PH_TEXT;
      if (grp.count == 2'd0) begin
        // empty end marker
        grp.data[0] = upd_pkg::CH_NUL;
        grp.data_ok = 1'b0;
        grp.count   = 2'd1;
      end
    end

    grp_load = fire && (grp.count != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= upd_pkg::PH_TEXT;
    end else if (fire) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && held_we) begin
      held <= cur_byte;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/upd_out_buf.sv -----
// Module: result group register, drained one result per cycle onto the output channel while it is ready.
`default_nettype none
module upd_out_buf (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire upd_pkg::group_t grp,
  input  wire logic            grp_load,
  output logic                 can_load,
  upd_out_if.source            egress
);

  logic [2:0][7:0] data;
  logic [1:0]      cnt;
  logic [1:0]      idx;
  logic            data_ok;
  logic            msg_last;
  logic            fire;

  assign fire     = egress.valid && egress.ready;
  assign can_load = (cnt == 2'd0) || ((cnt == 2'd1) && fire);

  always_comb begin
    egress.valid       = (cnt != 2'd0);
    egress.out_valid   = data_ok;
    egress.run_last    = (cnt == 2'd1);
    egress.message_end = (cnt == 2'd1) && msg_last;
    case (idx)
      2'd1:    egress.out_byte = data[1];
      2'd2:    egress.out_byte = data[2];
      default: egress.out_byte = data[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (grp_load) begin
      cnt <= grp.count;
    end else if (fire) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      data     <= grp.data;
      data_ok  <= grp.data_ok;
      msg_last <= grp.msg_last;
      idx      <= 2'd0;
    end else if (fire) begin
      idx <= idx + 2'd1;
    end
  end

endmodule
`default_nettype wire
